/* sv/lcr_pkg.sv */
// Shared types, field widths and arithmetic constants for the cubic Lagrange resampler.
package lcr_pkg;

	// Field and register widths
	localparam int RATE_W  = 24;
	localparam int SCNT_W  = 13;
	localparam int OCNT_W  = 16;
	localparam int LADDR_W = 12;
	localparam int SAMP_W  = 16;
	localparam int IDX_W   = 16;

	// Stream layout
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 2;
	localparam int LADDR_LSB = 0;
	localparam int LVAL_LSB  = LADDR_LSB + LADDR_W;
	localparam int IDX_LSB   = LVAL_LSB + SAMP_W;

	// Register port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Defaults for the top-level parameters
	localparam int MEM_DEPTH_DEF = 4096;
	localparam int FRAC_BITS_DEF = 16;

	// Fraction precision of the cubic evaluation
	localparam int CUBIC_BITS = 14;

	localparam logic [RATE_W-1:0] RATE_RESET = 24'd65536;

	// Register indexes (byte address / 4)
	typedef enum logic [1:0] {
		REG_RATE   = 2'd0,
		REG_SCOUNT = 2'd1,
		REG_OCOUNT = 2'd2
	} lcr_reg_t;

	// Input item kind
	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_INTERP = 1'b1
	} lcr_cmd_t;

	typedef logic signed [SAMP_W-1:0] lcr_samp_t;

	// Per-item flags carried down the arithmetic pipeline
	typedef struct packed {
		logic oor;
		logic linear;
	} lcr_tag_t;

endpackage

/* sv/lcr_sample_banks.sv */
// Sample memory split into four banks by address modulo 4, one read per bank per cycle.
module lcr_sample_banks #(
	parameter int MEM_DEPTH = lcr_pkg::MEM_DEPTH_DEF,
	localparam int BASE_W = $clog2((MEM_DEPTH + 3) / 4) + 2
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [lcr_pkg::LADDR_W-1:0]   wr_addr,
	input  lcr_pkg::lcr_samp_t            wr_data,
	input  logic                          rd_en,
	input  logic [BASE_W-1:0]             rd_base,
	output lcr_pkg::lcr_samp_t            rd_taps [4]
);

	localparam int BANK_DEPTH = (MEM_DEPTH + 3) / 4;
	localparam int WIDE_W = lcr_pkg::LADDR_W + BASE_W;

	logic [WIDE_W-1:0] wr_wide;
	logic [BASE_W-3:0] wr_row;
	logic              wr_ok;
	lcr_pkg::lcr_samp_t rd_q [4];
	logic [1:0]        rot_q;

	// Split the load address into bank and row; drop writes past the buffer
	assign wr_wide = WIDE_W'(wr_addr);
	assign wr_row  = wr_wide[BASE_W-1:2];
	assign wr_ok   = wr_en && (int'(wr_addr) < MEM_DEPTH);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		lcr_pkg::lcr_samp_t mem [BANK_DEPTH];
		logic [1:0]        koff;
		logic [BASE_W-1:0] rd_addr;

		// This bank serves the tap whose address has low bits equal to b
		assign koff    = 2'(b) - rd_base[1:0];
		assign rd_addr = rd_base + BASE_W'(koff);

		always_ff @(posedge clk) begin
			if (wr_ok && (wr_addr[1:0] == 2'(b))) begin
				mem[wr_row] <= wr_data;
			end
			if (rd_en) begin
				rd_q[b] <= mem[rd_addr[BASE_W-1:2]];
			end
		end
	end

	// Remember which bank holds the first tap
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rot_q <= rd_base[1:0];
		end
	end

	// Rotate bank outputs into tap order
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rd_taps[k] = rd_q[rot_q + 2'(k)];
		end
	end

endmodule

/* sv/lcr_interp_core.sv */
// Pipelined cubic (Horner form) and linear interpolation with rounding and saturation.
module lcr_interp_core #(
	parameter int FRAC_BITS = lcr_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lcr_pkg::lcr_samp_t            in_y [4],
	input  logic [FRAC_BITS-1:0]          in_frac,
	input  lcr_pkg::lcr_tag_t             in_tag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lcr_pkg::M_TDATA_W-1:0] out_data,
	output logic [lcr_pkg::M_TUSER_W-1:0] out_user
);

	localparam int CB     = lcr_pkg::CUBIC_BITS;
	localparam int SH_DN  = (FRAC_BITS >= CB) ? FRAC_BITS - CB : 0;
	localparam int SH_UP  = (FRAC_BITS >= CB) ? 0 : CB - FRAC_BITS;
	localparam int FW_W   = FRAC_BITS + CB;
	localparam int LP_W   = 17 + FRAC_BITS + 1;
	localparam logic [LP_W-1:0] LIN_HALF = LP_W'(1) << (FRAC_BITS - 1);
	// Round half up before dividing by 6*U^3: add 3*U^3
	localparam logic signed [65:0] CUB_HALF = 66'(3) << (3 * CB);
	// floor(x/6) for 0 <= x < 2^25 as (x * M) >> 26
	localparam logic [23:0] DIV6_M   = 24'd11184811;
	localparam logic [23:0] DIV6_OFS = 24'd6291456;
	localparam logic signed [23:0] DIV6_BIAS = 24'sd1048576;

	// Handshake chain
	logic v_s3, v_s4, v_s5, v_s6, v_s7, out_valid_q;
	logic rdy3, rdy4, rdy5, rdy6, rdy7, rdy_o;

	assign rdy_o    = !out_valid_q || out_ready;
	assign rdy7     = !v_s7 || rdy_o;
	assign rdy6     = !v_s6 || rdy7;
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign in_ready = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy3) v_s3 <= in_valid;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
			if (rdy_o) out_valid_q <= v_s7;
		end
	end

	// Stage 3: polynomial coefficients in y and the cubic fraction
	logic signed [18:0] e0, e1, e2, e3;
	logic signed [19:0] f0, f1, f2, f3;
	logic signed [18:0] k3_c;
	logic signed [19:0] k2_c, k1_c;
	logic signed [16:0] d_c;
	logic [FW_W-1:0]    fw;
	logic [CB-1:0]      u_c;

	always_comb begin
		e0 = 19'(in_y[0]);
		e1 = 19'(in_y[1]);
		e2 = 19'(in_y[2]);
		e3 = 19'(in_y[3]);
		f0 = 20'(in_y[0]);
		f1 = 20'(in_y[1]);
		f2 = 20'(in_y[2]);
		f3 = 20'(in_y[3]);
		k3_c = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
		k2_c = (f0 <<< 1) + f0 - (f1 <<< 2) - (f1 <<< 1) + (f2 <<< 1) + f2;
		k1_c = (f2 <<< 2) + (f2 <<< 1) - (f0 <<< 1) - (f1 <<< 1) - f1 - f3;
		d_c  = 17'(in_y[2]) - 17'(in_y[1]);
		fw   = FW_W'(in_frac);
		u_c  = CB'((fw >> SH_DN) << SH_UP);
	end

	logic signed [18:0]   k3_s3;
	logic signed [19:0]   k2_s3, k1_s3;
	logic signed [16:0]   d_s3;
	lcr_pkg::lcr_samp_t   y1_s3;
	logic [CB-1:0]        u_s3;
	logic [FRAC_BITS-1:0] frac_s3;
	lcr_pkg::lcr_tag_t    tag_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			k3_s3   <= k3_c;
			k2_s3   <= k2_c;
			k1_s3   <= k1_c;
			d_s3    <= d_c;
			y1_s3   <= in_y[1];
			u_s3    <= u_c;
			frac_s3 <= in_frac;
			tag_s3  <= in_tag;
		end
	end

	// Stage 4: first Horner step and the linear product
	logic signed [33:0]   p1_c;
	logic signed [LP_W-1:0] lp_c;
	logic signed [35:0]   h1_s4;
	logic signed [LP_W-1:0] lp_s4;
	logic signed [19:0]   k1_s4;
	lcr_pkg::lcr_samp_t   y1_s4;
	logic [CB-1:0]        u_s4;
	lcr_pkg::lcr_tag_t    tag_s4;

	assign p1_c = k3_s3 * $signed({1'b0, u_s3});
	assign lp_c = d_s3 * $signed({1'b0, frac_s3});

	always_ff @(posedge clk) begin
		if (rdy4) begin
			h1_s4  <= 36'(p1_c) + (36'(k2_s3) <<< CB);
			lp_s4  <= lp_c;
			k1_s4  <= k1_s3;
			y1_s4  <= y1_s3;
			u_s4   <= u_s3;
			tag_s4 <= tag_s3;
		end
	end

	// Stage 5: second Horner step; finish the linear result
	logic signed [50:0]     p2_c;
	logic signed [LP_W-1:0] lp_rnd;
	logic signed [LP_W-1:0] lp_sh;
	logic signed [50:0]     h2_s5;
	logic signed [17:0]     lin_s5;
	lcr_pkg::lcr_samp_t     y1_s5;
	logic [CB-1:0]          u_s5;
	lcr_pkg::lcr_tag_t      tag_s5;

	assign p2_c   = h1_s4 * $signed({1'b0, u_s4});
	assign lp_rnd = lp_s4 + $signed(LIN_HALF);
	assign lp_sh  = lp_rnd >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			h2_s5  <= p2_c + (51'(k1_s4) <<< (2 * CB));
			lin_s5 <= 18'(y1_s4) + 18'(lp_sh);
			y1_s5  <= y1_s4;
			u_s5   <= u_s4;
			tag_s5 <= tag_s4;
		end
	end

	// Stage 6: last Horner multiply, split into two partial products
	logic signed [40:0]  mhi_s6;
	logic [38:0]         mlo_s6;
	logic signed [17:0]  lin_s6;
	lcr_pkg::lcr_samp_t  y1_s6;
	lcr_pkg::lcr_tag_t   tag_s6;

	always_ff @(posedge clk) begin
		if (rdy6) begin
			mhi_s6 <= $signed(h2_s5[50:25]) * $signed({1'b0, u_s5});
			mlo_s6 <= h2_s5[24:0] * u_s5;
			lin_s6 <= lin_s5;
			y1_s6  <= y1_s5;
			tag_s6 <= tag_s5;
		end
	end

	// Stage 7: join partial products, round, scale by 2^-42, offset for the divide
	logic signed [65:0] num_c;
	logic signed [23:0] x_c;
	logic [23:0]        xp_s7;
	logic signed [17:0] lin_s7;
	lcr_pkg::lcr_samp_t y1_s7;
	lcr_pkg::lcr_tag_t  tag_s7;

	always_comb begin
		num_c = (66'(mhi_s6) <<< 25) + $signed(66'(mlo_s6)) + CUB_HALF;
		x_c   = num_c[65:3*CB];
	end

	always_ff @(posedge clk) begin
		if (rdy7) begin
			xp_s7  <= 24'(x_c) + DIV6_OFS;
			lin_s7 <= lin_s6;
			y1_s7  <= y1_s6;
			tag_s7 <= tag_s6;
		end
	end

	// Output: divide by 6, add y1, select, saturate
	logic [47:0]        qprod;
	logic [21:0]        q_c;
	logic signed [23:0] cub_c;
	logic signed [23:0] val_c;
	logic [15:0]        sat_c;
	logic [lcr_pkg::M_TDATA_W-1:0] out_data_q;
	logic [lcr_pkg::M_TUSER_W-1:0] out_user_q;

	always_comb begin
		qprod = xp_s7 * DIV6_M;
		q_c   = qprod[47:26];
		cub_c = 24'(y1_s7) + $signed({2'b00, q_c}) - DIV6_BIAS;
		val_c = tag_s7.linear ? 24'(lin_s7) : cub_c;
		priority if (val_c > 24'sd32767) begin
			sat_c = 16'h7fff;
		end else if (val_c < -24'sd32768) begin
			sat_c = 16'h8000;
		end else begin
			sat_c = val_c[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o) begin
			out_data_q <= tag_s7.oor ? '0 : sat_c;
			out_user_q <= {tag_s7.linear & ~tag_s7.oor, tag_s7.oor};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

/* sv/lagrange_cubic_resampler.sv */
// Top level of the cubic Lagrange resampler: register port, address stage and sample banks.
//
// Usage: program rate_q16 (0x0), sample_count (0x4) and output_count (0x8) over the
// register port while the block is idle, then send items on the s_ channel. s_tuser
// selects the item kind: 0 loads s_tdata.load_value at load_address, 1 asks for output
// sample output_index. Loads give no result; each interpolate item gives one result on
// the m_ channel: m_tdata is the saturated sample, m_tuser flags out of range and the
// linear edge fallback.
// Throughput is one item per cycle unless the m_ channel stalls; the sample memory is four
// banks interleaved by address, so the four taps of one item come out of a single read of
// the banks, and a load writes in the same pipeline step where later items read, which
// keeps loads and reads in order.
// Reset restores rate 1.0 and zero counts and empties the pipeline; memory contents are
// undefined until loaded. When the receiver stalls, results hold in the output register
// and earlier stages keep taking items until every stage is occupied, then s_tready falls.
module lagrange_cubic_resampler #(
	parameter int MEM_DEPTH = lcr_pkg::MEM_DEPTH_DEF,
	parameter int FRAC_BITS = lcr_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [11:0] load_address, [27:12] load_value, [43:28] output_index
	input  logic [lcr_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] command
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [15:0] sample_out
	output logic [lcr_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] out_of_range, [1] used_linear
	output logic [lcr_pkg::M_TUSER_W-1:0] m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lcr_pkg::APB_AW-1:0]    paddr,
	input  logic [lcr_pkg::APB_DW-1:0]    pwdata,
	output logic [lcr_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	localparam int POS_W  = lcr_pkg::RATE_W + lcr_pkg::IDX_W;
	localparam int INT_W  = POS_W - FRAC_BITS;
	localparam int TAP_W  = INT_W + 2;
	localparam int BASE_W = $clog2((MEM_DEPTH + 3) / 4) + 2;

	// Configuration registers
	logic [lcr_pkg::RATE_W-1:0] rate_q;
	logic [lcr_pkg::SCNT_W-1:0] scount_q;
	logic [lcr_pkg::OCNT_W-1:0] ocount_q;
	logic                       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= lcr_pkg::RATE_RESET;
			scount_q <= '0;
			ocount_q <= '0;
		end else if (cfg_wr) begin
			unique case (lcr_pkg::lcr_reg_t'(paddr[3:2]))
				lcr_pkg::REG_RATE:   rate_q   <= pwdata[lcr_pkg::RATE_W-1:0];
				lcr_pkg::REG_SCOUNT: scount_q <= pwdata[lcr_pkg::SCNT_W-1:0];
				lcr_pkg::REG_OCOUNT: ocount_q <= pwdata[lcr_pkg::OCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (lcr_pkg::lcr_reg_t'(paddr[3:2]))
			lcr_pkg::REG_RATE:   prdata = lcr_pkg::APB_DW'(rate_q);
			lcr_pkg::REG_SCOUNT: prdata = lcr_pkg::APB_DW'(scount_q);
			lcr_pkg::REG_OCOUNT: prdata = lcr_pkg::APB_DW'(ocount_q);
			default:             prdata = '0;
		endcase
	end

	// Unpack the input transfer
	logic [lcr_pkg::LADDR_W-1:0] in_laddr;
	lcr_pkg::lcr_samp_t          in_lval;
	logic [lcr_pkg::IDX_W-1:0]   in_idx;

	assign in_laddr = s_tdata[lcr_pkg::LADDR_LSB +: lcr_pkg::LADDR_W];
	assign in_lval  = s_tdata[lcr_pkg::LVAL_LSB +: lcr_pkg::SAMP_W];
	assign in_idx   = s_tdata[lcr_pkg::IDX_LSB +: lcr_pkg::IDX_W];

	// Handshake chain
	logic v_s1, v_s2;
	logic rdy2, core_ready;

	assign rdy2     = !v_s2 || core_ready;
	assign s_tready = !v_s1 || rdy2;

	// Stage 1: position product and range check
	lcr_pkg::lcr_cmd_t           cmd_s1;
	logic [lcr_pkg::LADDR_W-1:0] laddr_s1;
	lcr_pkg::lcr_samp_t          lval_s1;
	logic [POS_W-1:0]            pos_s1;
	logic                        oor_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1 && (cmd_s1 == lcr_pkg::CMD_INTERP);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			cmd_s1   <= lcr_pkg::lcr_cmd_t'(s_tuser[0]);
			laddr_s1 <= in_laddr;
			lval_s1  <= in_lval;
			pos_s1   <= POS_W'(rate_q) * POS_W'(in_idx);
			oor_s1   <= (in_idx >= ocount_q);
		end
	end

	// Split position, edge test and per-tap bounds against the loaded length
	logic [INT_W-1:0]     int_s1;
	logic [FRAC_BITS-1:0] frac_c;
	logic [TAP_W-1:0]     s_ext, n_lim, base_c;
	logic                 linear_c;
	logic [3:0]           tapv_c;

	always_comb begin
		int_s1   = pos_s1[POS_W-1:FRAC_BITS];
		frac_c   = pos_s1[FRAC_BITS-1:0];
		s_ext    = TAP_W'(int_s1);
		n_lim    = (int'(scount_q) > MEM_DEPTH) ? TAP_W'(MEM_DEPTH) : TAP_W'(scount_q);
		linear_c = (s_ext <= TAP_W'(1)) || ((s_ext + TAP_W'(2)) >= n_lim);
		base_c   = s_ext - TAP_W'(1);
		for (int k = 0; k < 4; k++) begin
			tapv_c[k] = (base_c + TAP_W'(k)) < n_lim;
		end
	end

	// Sample banks: loads write and interpolates read as they leave stage 1
	logic                wr_en;
	lcr_pkg::lcr_samp_t  taps [4];

	assign wr_en = v_s1 && (cmd_s1 == lcr_pkg::CMD_LOAD) && rdy2;

	lcr_sample_banks #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_banks (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (laddr_s1),
		.wr_data (lval_s1),
		.rd_en   (rdy2),
		.rd_base (base_c[BASE_W-1:0]),
		.rd_taps (taps)
	);

	// Stage 2: hold item data alongside the bank read
	logic [FRAC_BITS-1:0] frac_s2;
	logic [3:0]           tapv_s2;
	lcr_pkg::lcr_tag_t    tag_s2;
	lcr_pkg::lcr_samp_t   y_s2 [4];

	always_ff @(posedge clk) begin
		if (rdy2) begin
			frac_s2       <= frac_c;
			tapv_s2       <= tapv_c;
			tag_s2.oor    <= oor_s1;
			tag_s2.linear <= linear_c;
		end
	end

	// Taps outside the loaded length read as zero
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			y_s2[k] = tapv_s2[k] ? taps[k] : '0;
		end
	end

	lcr_interp_core #(
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (core_ready),
		.in_y      (y_s2),
		.in_frac   (frac_s2),
		.in_tag    (tag_s2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule

/* test/lagrange_cubic_resampler_check.sv */
`timescale 1ns / 1ps
// Checker for the cubic Lagrange resampler: predicts each result and compares it.
module lagrange_cubic_resampler_check #(
	parameter int MEM_DEPTH = lcr_pkg::MEM_DEPTH_DEF,
	parameter int FRAC_BITS = lcr_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// [11:0] load_address, [27:12] load_value, [43:28] output_index
	input  logic [lcr_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] command
	input  logic [0:0]                    s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// [15:0] sample_out
	input  logic [lcr_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] out_of_range, [1] used_linear
	input  logic [lcr_pkg::M_TUSER_W-1:0] m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lcr_pkg::APB_AW-1:0]    paddr,
	input  logic [lcr_pkg::APB_DW-1:0]    pwdata,
	input  logic                          pready,
	output int                            mismatch_count,
	output int                            samples_in_flight
);
	import lcr_pkg::*;

	typedef struct packed {
		lcr_samp_t sample;
		lcr_tag_t  flags;
	} resampled_t;

	// Shadow copies of the registers and the sample memory
	logic [RATE_W-1:0] rate_reg   = RATE_RESET;
	logic [SCNT_W-1:0] scount_reg = '0;
	logic [OCNT_W-1:0] ocount_reg = '0;
	logic [SAMP_W-1:0] sample_mem [MEM_DEPTH];

	// Results predicted but not yet seen, oldest first
	resampled_t awaited_samples [$];

	// Read one stored sample; anything outside the valid buffer reads as zero
	function automatic longint stored_sample(input longint a, input longint n);
		if (a < 0 || a >= n)
			return 0;
		return longint'($signed(sample_mem[a]));
	endfunction

	// Work out the output sample for one requested index
	function automatic resampled_t interpolate_point(input logic [IDX_W-1:0] index);
		resampled_t r;
		longint pos, s, frac, n, u, uu, y0, y1, y2, y3, v, num, den;
		r = '0;
		if (index >= ocount_reg) begin
			r.flags.oor = 1'b1;
			return r;
		end
		pos  = longint'(rate_reg) * longint'(index);
		s    = pos >>> FRAC_BITS;
		frac = pos & ((longint'(1) << FRAC_BITS) - 1);
		n    = (scount_reg > MEM_DEPTH) ? MEM_DEPTH : scount_reg;
		y0   = stored_sample(s - 1, n);
		y1   = stored_sample(s, n);
		y2   = stored_sample(s + 1, n);
		y3   = stored_sample(s + 2, n);
		// fall back to linear near either end of the buffer
		r.flags.linear = (s <= 1) || (s >= n - 2);
		if (r.flags.linear) begin
			v = y1 + (((y2 - y1) * frac + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
		end else begin
			uu = longint'(1) << CUBIC_BITS;
			u = (FRAC_BITS >= CUBIC_BITS) ? (frac >>> (FRAC_BITS - CUBIC_BITS))
				: (frac <<< (CUBIC_BITS - FRAC_BITS));
			num = -(u * (u - uu) * (u - 2 * uu)) * y0
				+ 3 * ((uu + u) * (u - uu) * (u - 2 * uu)) * y1
				- 3 * ((uu + u) * u * (u - 2 * uu)) * y2
				+ ((uu + u) * u * (u - uu)) * y3;
			den = 6 * uu * uu * uu;
			// round half up, flooring toward minus infinity
			num = num + den / 2;
			v = (num >= 0) ? num / den : -((-num + den - 1) / den);
		end
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		r.sample = v[SAMP_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Follow every transfer on the three channels
	always @(posedge clk) begin : watch
		resampled_t        want;
		logic [LADDR_W-1:0] addr;
		if (!arst_n) begin
			rate_reg       = RATE_RESET;
			scount_reg     = '0;
			ocount_reg     = '0;
			mismatch_count = 0;
			awaited_samples.delete();
		end else begin
			// compare the result against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (awaited_samples.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h / %b",
						$time, m_tdata, m_tuser);
					mismatch_count++;
				end else begin
					want = awaited_samples.pop_front();
					check_field("sample_out", want.sample, $signed(m_tdata));
					check_field("out_of_range", want.flags.oor, m_tuser[0]);
					check_field("used_linear", want.flags.linear, m_tuser[1]);
				end
			end
			// track register writes
			if (psel && penable && pwrite && pready) begin
				case (lcr_reg_t'(paddr[APB_AW-1:2]))
					REG_RATE:   rate_reg = pwdata[RATE_W-1:0];
					REG_SCOUNT: scount_reg = pwdata[SCNT_W-1:0];
					REG_OCOUNT: ocount_reg = pwdata[OCNT_W-1:0];
					default: ;
				endcase
			end
			// apply loads, predict interpolations
			if (s_tvalid && s_tready) begin
				if (lcr_cmd_t'(s_tuser[0]) == CMD_LOAD) begin
					addr = s_tdata[LADDR_LSB +: LADDR_W];
					if (addr < MEM_DEPTH)
						sample_mem[addr] = s_tdata[LVAL_LSB +: SAMP_W];
				end else begin
					awaited_samples.push_back(interpolate_point(s_tdata[IDX_LSB +: IDX_W]));
				end
			end
		end
		samples_in_flight = awaited_samples.size();
	end

endmodule

/* test/lagrange_cubic_resampler_test.sv */
`timescale 1ns / 1ps
// Top of the resampler testbench: clock, reset, register setup, stimulus and verdict.
module lagrange_cubic_resampler_test;
	import lcr_pkg::*;

	localparam int MEM_DEPTH   = MEM_DEPTH_DEF;
	localparam int FRAC_BITS   = FRAC_BITS_DEF;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 230;
	localparam int LOAD_BURST  = 40;
	localparam int LATENCY     = 7;
	localparam int STALL_LIMIT = 5000;

	// Buffer with full-scale swings so the cubic overshoots both rails, a0 lowest
	localparam logic [10*SAMP_W-1:0] EDGE_WORDS = {
		16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
		16'h7FFF, 16'h8000, 16'd1000, 16'h7FFF, 16'h8000
	};
	// At rate 0.5: linear start, cubic, both rails, end edge, past buffer, out of range
	localparam logic [10*IDX_W-1:0] PROBE_INDEX = {
		16'd65535, 16'd26, 16'd25, 16'd19, 16'd17,
		16'd13, 16'd9, 16'd5, 16'd3, 16'd0
	};

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [0:0]           s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [APB_AW-1:0]    paddr    = '0;
	logic [APB_DW-1:0]    pwdata   = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	int mismatch_count;
	int samples_in_flight;
	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;

	// What has been programmed and loaded, used to steer the indices
	longint rate_set   = 65536;
	longint scount_set = 0;
	longint ocount_set = 0;
	bit     loaded [MEM_DEPTH];

	lagrange_cubic_resampler uut (.*);
	lagrange_cubic_resampler_check watch (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result side at random
	always @(negedge clk)
		m_tready = ($urandom_range(0, 99) >= recv_stall_pct);

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else if (quiet_cycles == STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Write one register with a setup and an access cycle
	task automatic write_reg(input lcr_reg_t which, input longint value);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {which, 2'b00};
		pwdata  = value[APB_DW-1:0];
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		case (which)
			REG_RATE:   rate_set = value;
			REG_SCOUNT: scount_set = value;
			default:    ocount_set = value;
		endcase
	endtask

	// Offer one item and hold it until the transfer
	task automatic send_item(input lcr_cmd_t cmd, input logic [LADDR_W-1:0] addr,
		input logic [SAMP_W-1:0] value, input logic [IDX_W-1:0] index);
		logic [S_TDATA_W-1:0] word;
		word = '0;
		word[LADDR_LSB +: LADDR_W] = addr;
		word[LVAL_LSB +: SAMP_W]   = value;
		word[IDX_LSB +: IDX_W]     = index;
		if (cmd == CMD_LOAD)
			loaded[addr] = 1'b1;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = word;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Hold off until every result is back, then let loads settle
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (samples_in_flight != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	initial begin
		int                 p, k, pick, tries;
		longint             n, span, s, a, index, limit;
		bit                 clear;
		logic [LADDR_W-1:0] addr;
		logic [SAMP_W-1:0]  value;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: ten samples at rate 0.5, probing each region of the buffer
		write_reg(REG_RATE, 32768);
		write_reg(REG_SCOUNT, 10);
		write_reg(REG_OCOUNT, 26);
		for (k = 0; k < 10; k++)
			send_item(CMD_LOAD, LADDR_W'(k), EDGE_WORDS[k*SAMP_W +: SAMP_W],
				IDX_W'($urandom));
		send_item(CMD_LOAD, 12'hFFF, 16'h5A5A, IDX_W'($urandom));
		for (k = 0; k < 10; k++)
			send_item(CMD_INTERP, LADDR_W'($urandom), SAMP_W'($urandom),
				PROBE_INDEX[k*IDX_W +: IDX_W]);
		wait_idle();
		// rate zero pins every position to the first sample
		write_reg(REG_RATE, 0);
		send_item(CMD_INTERP, LADDR_W'($urandom), SAMP_W'($urandom), 16'd20);
		wait_idle();

		// Random phases, each with its own settings and idling pattern
		for (p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_gap_pct = 88; recv_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct = 88; end
				default: begin send_gap_pct = 12; recv_stall_pct = 12; end
			endcase
			case (p)
				0: begin
					write_reg(REG_RATE, 65536);
					write_reg(REG_SCOUNT, 64);
					write_reg(REG_OCOUNT, 200);
				end
				1: begin
					write_reg(REG_RATE, 1);
					write_reg(REG_SCOUNT, MEM_DEPTH);
					write_reg(REG_OCOUNT, 65535);
				end
				2: begin
					write_reg(REG_RATE, 24'hFFFFFF);
					write_reg(REG_SCOUNT, 0);
					write_reg(REG_OCOUNT, 65535);
				end
				3: begin
					write_reg(REG_RATE, $urandom_range(16384, 262143));
					write_reg(REG_SCOUNT, $urandom_range(8, 300));
					write_reg(REG_OCOUNT, 0);
				end
				default: begin
					write_reg(REG_RATE, $urandom_range(16384, 262143));
					write_reg(REG_SCOUNT, $urandom_range(4, 400));
					write_reg(REG_OCOUNT, $urandom_range(1, 65535));
				end
			endcase
			n = (scount_set > MEM_DEPTH) ? MEM_DEPTH : scount_set;
			span = ((n + 3) << FRAC_BITS) / rate_set;
			if (span > 65535)
				span = 65535;
			// keep loads near the taps that the chosen indices can reach
			limit = ((rate_set * span) >>> FRAC_BITS) + 3;
			if (limit > n + 3)
				limit = n + 3;
			if (limit > MEM_DEPTH - 1)
				limit = MEM_DEPTH - 1;

			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2)
					wait_idle();
				if (k < LOAD_BURST || $urandom_range(0, 3) == 0) begin
					// load, mostly into the valid part of the buffer
					addr = ($urandom_range(0, 99) < 80) ? LADDR_W'($urandom_range(0, limit))
						: LADDR_W'($urandom_range(0, MEM_DEPTH - 1));
					pick = $urandom_range(0, 9);
					value = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF
						: SAMP_W'($urandom);
					send_item(CMD_LOAD, addr, value, IDX_W'($urandom));
				end else begin
					// pick an index whose taps inside the buffer have all been loaded
					index = 0;
					for (tries = 0; tries < 16; tries++) begin
						pick = $urandom_range(0, 99);
						if (pick < 70)
							index = $urandom_range(0, span);
						else if (pick < 85)
							index = ocount_set - 1 + longint'($urandom_range(0, 2));
						else
							index = $urandom_range(0, 65535);
						if (index < 0)
							index = 0;
						if (index > 65535)
							index = 65535;
						clear = 1'b1;
						if (index < ocount_set) begin
							s = (rate_set * index) >>> FRAC_BITS;
							for (a = s - 1; a <= s + 2; a++)
								if (a >= 0 && a < n && !loaded[a])
									clear = 1'b0;
						end
						if (clear)
							break;
						// fall back to an index past the end, which reads no samples
						index = ocount_set;
					end
					send_item(CMD_INTERP, LADDR_W'($urandom), SAMP_W'($urandom),
						index[IDX_W-1:0]);
				end
			end
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* lagrange_cubic_resampler.f */
sv/lcr_pkg.sv
sv/lcr_sample_banks.sv
sv/lcr_interp_core.sv
sv/lagrange_cubic_resampler.sv
test/lagrange_cubic_resampler_check.sv
test/lagrange_cubic_resampler_test.sv
